### hw/rtl/pds_pkg.sv
// shared types, widths and constants of the pll divider search block
`default_nettype none

package pds_pkg;

  localparam int unsigned TARGET_W   = 19;
  localparam int unsigned REF_W      = 16;
  localparam int unsigned MAXM_W     = 11;
  localparam int unsigned MAXN_W     = 8;
  localparam int unsigned P_W        = 3;
  localparam int unsigned VCO_W      = 20;
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned TS_W       = TARGET_W + SCALE_W;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned Q_W        = MAXM_W + 1;
  localparam int unsigned DN_W       = 12;
  localparam int unsigned PROD_W     = REF_W + Q_W;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [REF_W-1:0]  RST_REF_CLOCK = 16'd14318;
  localparam logic [MAXM_W-1:0] RST_MAX_M     = 11'd2047;
  localparam logic [MAXN_W-1:0] RST_MAX_N     = 8'd255;
  localparam logic [P_W-1:0]    RST_MAX_P     = 3'd7;
  localparam logic [VCO_W-1:0]  RST_MIN_VCO   = 20'd115000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_REF_CLOCK = 3'd0,
    REG_MAX_M     = 3'd1,
    REG_MAX_N     = 3'd2,
    REG_MAX_P     = 3'd3,
    REG_MIN_VCO   = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PSEARCH,
    ST_NINIT,
    ST_DIV_Q,
    ST_WAIT_Q,
    ST_MUL,
    ST_WAIT_MUL,
    ST_DIV_F,
    ST_WAIT_F,
    ST_NEXT,
    ST_DONE
  } state_e;

  // post divider scale: 1 for code 0, twice the code otherwise
  function automatic logic [SCALE_W-1:0] scale_of(input logic [P_W-1:0] p);
    logic [SCALE_W-1:0] s;
    if (p == '0) begin
      s = SCALE_W'(1);
    end else begin
      s = {p, 1'b0};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pll_divider_search_top.sv
// Finds PLL dividers M, N, P for a target output clock in kHz.
// Input stream: s_axis_tdata carries target_khz; one transaction starts one search.
// Output stream: one transaction per search with M, N, P in tdata and found and
// vco_low in tuser. The user must write registers through cfg_we_i / cfg_addr_i /
// cfg_wdata_i only while no search runs; the block does not enforce this. Writes
// to indexes above 4 are ignored. A search first steps the post divider up until
// the VCO floor or max P is reached and sets up the N loop, then for each N from 1
// to max_n runs a serial division for M or, when M is legal, that division plus a
// serial multiply and a second serial division for the output clock.
// Throughput is one search at a time: s_axis_tready is high only while idle.
// The result sits in an output register; the next target is taken while it waits,
// and a stalled receiver only holds the block before it writes the next result.
// Reset clears the control state and loads the register defaults
// (ref 14318 kHz, max M 2047, max N 255, max P 7, min VCO 115000 kHz).
`default_nettype none

module pll_divider_search_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [23:0]                      s_axis_tdata,   // target_khz
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [23:0]                      m_axis_tdata,   // m_value, n_value, p_value
  output logic      [1:0]                       m_axis_tuser,   // found, vco_low
  input  wire logic                             cfg_we_i,
  input  wire logic [pds_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [pds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned TARGET_W = pds_pkg::TARGET_W;
  localparam int unsigned REF_W    = pds_pkg::REF_W;
  localparam int unsigned MAXM_W   = pds_pkg::MAXM_W;
  localparam int unsigned MAXN_W   = pds_pkg::MAXN_W;
  localparam int unsigned P_W      = pds_pkg::P_W;
  localparam int unsigned VCO_W    = pds_pkg::VCO_W;
  localparam int unsigned SCALE_W  = pds_pkg::SCALE_W;
  localparam int unsigned TS_W     = pds_pkg::TS_W;
  localparam int unsigned NUM_W    = pds_pkg::NUM_W;
  localparam int unsigned Q_W      = pds_pkg::Q_W;
  localparam int unsigned DN_W     = pds_pkg::DN_W;
  localparam int unsigned PROD_W   = pds_pkg::PROD_W;

  // configuration registers
  logic [REF_W-1:0]  ref_clock_q;
  logic [MAXM_W-1:0] max_m_q;
  logic [MAXN_W-1:0] max_n_q;
  logic [P_W-1:0]    max_p_q;
  logic [VCO_W-1:0]  min_vco_q;

  pds_pkg::state_e state_q, state_d;

  logic [TARGET_W-1:0] target_q;
  logic [P_W-1:0]      p_q;
  logic                reached_q;
  logic [TS_W-1:0]     ts_q;
  logic [NUM_W-1:0]    num_q;
  logic [DN_W-1:0]     dn_q;
  logic [MAXN_W-1:0]   n_q;
  logic [Q_W-1:0]      q_q;
  logic [TARGET_W-1:0] besterr_q;
  logic [MAXM_W-1:0]   best_m_q;
  logic [MAXN_W-1:0]   best_n_q;
  logic                found_q;

  logic                out_valid_q;
  logic [23:0]         out_data_q;
  logic [1:0]          out_user_q;

  logic [REF_W-1:0]    ref_eff;
  logic [SCALE_W-1:0]  scale;
  logic [TS_W-1:0]     tsc;
  logic                out_free;

  logic                div_start, mul_start;
  logic [NUM_W-1:0]    div_dividend;
  logic [REF_W-1:0]    div_divisor;
  logic                div_done;
  logic [NUM_W-1:0]    div_quot;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;

  logic                q_legal;
  logic [PROD_W-1:0]   f_out;
  logic [PROD_W-1:0]   tgt_ext;
  logic [PROD_W-1:0]   err;
  logic                better;

  assign ref_eff  = (ref_clock_q == '0) ? REF_W'(1) : ref_clock_q;
  assign scale    = pds_pkg::scale_of(p_q);
  assign tsc      = TS_W'(target_q) * TS_W'(scale);
  assign out_free = !out_valid_q || m_axis_tready;

  // rounded quotient gives M + 1; zero or too large means no legal M
  assign q_legal = (div_quot != '0) && (div_quot <= (NUM_W'(max_m_q) + NUM_W'(1)));

  assign f_out   = div_quot[PROD_W-1:0];
  assign tgt_ext = PROD_W'(target_q);
  assign err     = (tgt_ext >= f_out) ? (tgt_ext - f_out) : (f_out - tgt_ext);
  assign better  = err < PROD_W'(besterr_q);

  assign div_dividend = (state_q == pds_pkg::ST_DIV_F) ? NUM_W'(mul_prod)
                                                       : num_q + NUM_W'(ref_eff >> 1);
  assign div_divisor  = (state_q == pds_pkg::ST_DIV_F) ? REF_W'(dn_q) : ref_eff;

  pds_div_serial #(
    .DVD_W(NUM_W),
    .DVS_W(REF_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  pds_mul_serial #(
    .A_W(REF_W),
    .B_W(Q_W)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (ref_eff),
    .b_i      (q_q),
    .done_o   (mul_done),
    .product_o(mul_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pds_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = pds_pkg::ST_PSEARCH;
      end
      pds_pkg::ST_PSEARCH: begin
        if ((VCO_W'(tsc) >= min_vco_q && TS_W <= VCO_W) ||
            (TS_W > VCO_W && tsc >= TS_W'(min_vco_q)) || p_q == max_p_q) begin
          state_d = pds_pkg::ST_NINIT;
        end
      end
      pds_pkg::ST_NINIT: begin
        state_d = (max_n_q == '0) ? pds_pkg::ST_DONE : pds_pkg::ST_DIV_Q;
      end
      pds_pkg::ST_DIV_Q:    state_d = pds_pkg::ST_WAIT_Q;
      pds_pkg::ST_WAIT_Q: begin
        if (div_done) state_d = q_legal ? pds_pkg::ST_MUL : pds_pkg::ST_NEXT;
      end
      pds_pkg::ST_MUL:      state_d = pds_pkg::ST_WAIT_MUL;
      pds_pkg::ST_WAIT_MUL: begin
        if (mul_done) state_d = pds_pkg::ST_DIV_F;
      end
      pds_pkg::ST_DIV_F:    state_d = pds_pkg::ST_WAIT_F;
      pds_pkg::ST_WAIT_F: begin
        if (div_done) state_d = pds_pkg::ST_NEXT;
      end
      pds_pkg::ST_NEXT: begin
        state_d = (n_q == max_n_q) ? pds_pkg::ST_DONE : pds_pkg::ST_DIV_Q;
      end
      pds_pkg::ST_DONE: begin
        if (out_free) state_d = pds_pkg::ST_IDLE;
      end
      default: state_d = pds_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    case (state_q)
      pds_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      pds_pkg::ST_DIV_Q: div_start     = 1'b1;
      pds_pkg::ST_DIV_F: div_start     = 1'b1;
      pds_pkg::ST_MUL:   mul_start     = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pds_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      ref_clock_q <= pds_pkg::RST_REF_CLOCK;
      max_m_q     <= pds_pkg::RST_MAX_M;
      max_n_q     <= pds_pkg::RST_MAX_N;
      max_p_q     <= pds_pkg::RST_MAX_P;
      min_vco_q   <= pds_pkg::RST_MIN_VCO;
    end else begin
      state_q <= state_d;
      if (state_q == pds_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          pds_pkg::REG_REF_CLOCK: ref_clock_q <= cfg_wdata_i[REF_W-1:0];
          pds_pkg::REG_MAX_M:     max_m_q     <= cfg_wdata_i[MAXM_W-1:0];
          pds_pkg::REG_MAX_N:     max_n_q     <= cfg_wdata_i[MAXN_W-1:0];
          pds_pkg::REG_MAX_P:     max_p_q     <= cfg_wdata_i[P_W-1:0];
          pds_pkg::REG_MIN_VCO:   min_vco_q   <= cfg_wdata_i[VCO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pds_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          target_q <= s_axis_tdata[TARGET_W-1:0];
          p_q      <= '0;
        end
      end
      pds_pkg::ST_PSEARCH: begin
        if (TS_W'(min_vco_q) <= tsc) begin
          reached_q <= 1'b1;
        end else if (p_q == max_p_q) begin
          reached_q <= 1'b0;
        end else begin
          p_q <= p_q + P_W'(1);
        end
      end
      pds_pkg::ST_NINIT: begin
        ts_q      <= tsc;
        num_q     <= NUM_W'(tsc) << 1;
        dn_q      <= DN_W'(scale) << 1;
        n_q       <= MAXN_W'(1);
        besterr_q <= target_q;
        best_m_q  <= '0;
        best_n_q  <= '0;
        found_q   <= 1'b0;
      end
      pds_pkg::ST_WAIT_Q: begin
        if (div_done) q_q <= div_quot[Q_W-1:0];
      end
      pds_pkg::ST_WAIT_F: begin
        if (div_done && better) begin
          besterr_q <= err[TARGET_W-1:0];
          best_m_q  <= MAXM_W'(q_q - Q_W'(1));
          best_n_q  <= n_q;
          found_q   <= 1'b1;
        end
      end
      pds_pkg::ST_NEXT: begin
        n_q   <= n_q + MAXN_W'(1);
        num_q <= num_q + NUM_W'(ts_q);
        dn_q  <= dn_q + DN_W'(scale);
      end
      pds_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_q <= {2'b00, p_q, best_n_q, best_m_q};
          out_user_q <= {!reached_q, found_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

### hw/rtl/pds_div_serial.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module pds_div_serial #(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DVS_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             q_bit;

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign q_bit   = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // quotient bits shift in behind the dividend bits
      dvd_d = {dvd_q[DVD_W-2:0], q_bit};
      rem_d = q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

### hw/rtl/pds_mul_serial.sv
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module pds_mul_serial #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic                    done_o,
  output logic      [A_W+B_W-1:0] product_o
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);
  localparam int unsigned P_W   = A_W + B_W;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [A_W-1:0]   a_q, a_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [P_W-1:0]   acc_q, acc_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(B_W);
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      // msb first: double the partial sum, then add the multiplicand
      acc_d = {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
      b_d   = {b_q[B_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

### bench/pll_divider_search_top_tb.sv
// self-checking testbench for the pll divider search block
`timescale 1ns / 100ps

module pll_divider_search_top_tb;

  localparam int unsigned TARGET_MAX      = (1 << pds_pkg::TARGET_W) - 1;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 12;
  localparam int unsigned WATCHDOG_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES    = 100;

  // register indexes the block has no register behind
  localparam logic [pds_pkg::CFG_ADDR_W-1:0] SPARE_REG_LO = 3'd5;
  localparam logic [pds_pkg::CFG_ADDR_W-1:0] SPARE_REG_HI = 3'd7;

  typedef struct packed {
    logic [pds_pkg::MAXM_W-1:0] m_value;
    logic [pds_pkg::MAXN_W-1:0] n_value;
    logic [pds_pkg::P_W-1:0]    p_value;
    logic                       found;
    logic                       vco_low;
  } divider_result_t;

  typedef struct packed {
    logic [pds_pkg::TARGET_W-1:0] target;
    divider_result_t              result;
  } search_record_t;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [pds_pkg::CFG_ADDR_W-1:0] addr;
    logic [pds_pkg::CFG_DATA_W-1:0] data;
    logic [pds_pkg::TARGET_W-1:0]   target;
    bit                             typed;
    divider_result_t                want;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [23:0]                    s_axis_tdata = '0;   // target_khz
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [23:0]                    m_axis_tdata;        // m_value, n_value, p_value
  logic [1:0]                     m_axis_tuser;        // found, vco_low
  logic                           cfg_we_i = 1'b0;
  logic [pds_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [pds_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // copy of the register file as the block should hold it
  logic [pds_pkg::REF_W-1:0]  cfg_ref_khz = pds_pkg::RST_REF_CLOCK;
  logic [pds_pkg::MAXM_W-1:0] cfg_max_m   = pds_pkg::RST_MAX_M;
  logic [pds_pkg::MAXN_W-1:0] cfg_max_n   = pds_pkg::RST_MAX_N;
  logic [pds_pkg::P_W-1:0]    cfg_max_p   = pds_pkg::RST_MAX_P;
  logic [pds_pkg::VCO_W-1:0]  cfg_min_vco = pds_pkg::RST_MIN_VCO;

  search_record_t pending_results[$];
  stim_row_t      dir_rows[$];
  bit             idle_on = 1'b1;
  int unsigned    mismatch_count = 0;
  int unsigned    out_stall_left = 0;
  int unsigned    quiet_cycles = 0;

  pll_divider_search_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned post_scale(input int unsigned p);
    return (p == 0) ? 64'd1 : 64'(2 * p);
  endfunction

  // smallest post divider reaching the vco floor, then the n with the closest output clock
  function automatic divider_result_t search_dividers(
      input logic [pds_pkg::TARGET_W-1:0] target);
    longint unsigned tgt, refc, scale, best_err, q, m, f_out, err;
    int unsigned p;
    bit reached;
    divider_result_t r;
    tgt = target;
    refc = (cfg_ref_khz == 0) ? 64'd1 : 64'(cfg_ref_khz);
    reached = 1'b0;
    p = cfg_max_p;
    for (int k = 0; k <= int'(cfg_max_p); k++) begin
      if (!reached && tgt * post_scale(k) >= 64'(cfg_min_vco)) begin
        reached = 1'b1;
        p = k;
      end
    end
    scale = post_scale(p);
    r = '0;
    r.p_value = p[pds_pkg::P_W-1:0];
    r.vco_low = !reached;
    best_err = tgt;
    for (int n = 1; n <= int'(cfg_max_n); n++) begin
      q = (tgt * (n + 1) * scale + refc / 2) / refc;
      if (q == 0) continue;
      m = q - 1;
      if (m > 64'(cfg_max_m)) continue;
      f_out = (refc * (m + 1)) / ((n + 1) * scale);
      err = (tgt >= f_out) ? tgt - f_out : f_out - tgt;
      // strict compare keeps the smaller n on a tie
      if (err < best_err) begin
        best_err = err;
        r.m_value = m[pds_pkg::MAXM_W-1:0];
        r.n_value = n[pds_pkg::MAXN_W-1:0];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // mostly targets built from a legal m, n, p so the search finds something
  function automatic logic [pds_pkg::TARGET_W-1:0] random_target();
    longint unsigned refc, t;
    int unsigned m, n, pc;
    if ($urandom_range(0, 3) == 0) begin
      return 19'($urandom_range(0, TARGET_MAX));
    end
    refc = (cfg_ref_khz == 0) ? 64'd1 : 64'(cfg_ref_khz);
    m = $urandom_range(0, cfg_max_m);
    n = $urandom_range(1, (cfg_max_n == 0) ? 1 : cfg_max_n);
    pc = $urandom_range(0, 7);
    t = refc * (m + 1) / ((n + 1) * post_scale(pc)) + $urandom_range(0, 3);
    if (t > TARGET_MAX) t = $urandom_range(0, TARGET_MAX);
    return t[pds_pkg::TARGET_W-1:0];
  endfunction

  task automatic add_write(input logic [pds_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [pds_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.addr = addr;
    row.data = data;
    dir_rows.push_back(row);
  endtask

  task automatic add_item(input logic [pds_pkg::TARGET_W-1:0] target, input bit typed,
                          input logic [pds_pkg::MAXM_W-1:0] m,
                          input logic [pds_pkg::MAXN_W-1:0] n,
                          input logic [pds_pkg::P_W-1:0] p, input bit found,
                          input bit vco_low);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.target = target;
    row.typed = typed;
    row.want.m_value = m;
    row.want.n_value = n;
    row.want.p_value = p;
    row.want.found = found;
    row.want.vco_low = vco_low;
    dir_rows.push_back(row);
  endtask

  // registers only change once every search has been collected
  task automatic write_reg(input logic [pds_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [pds_pkg::CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      pds_pkg::REG_REF_CLOCK: cfg_ref_khz = data[pds_pkg::REF_W-1:0];
      pds_pkg::REG_MAX_M:     cfg_max_m = data[pds_pkg::MAXM_W-1:0];
      pds_pkg::REG_MAX_N:     cfg_max_n = data[pds_pkg::MAXN_W-1:0];
      pds_pkg::REG_MAX_P:     cfg_max_p = data[pds_pkg::P_W-1:0];
      pds_pkg::REG_MIN_VCO:   cfg_min_vco = data[pds_pkg::VCO_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_target(input logic [pds_pkg::TARGET_W-1:0] target, input bit typed,
                             input divider_result_t want);
    search_record_t rec;
    s_axis_tdata <= {{(24 - pds_pkg::TARGET_W){1'b0}}, target};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rec.target = target;
    rec.result = typed ? want : search_dividers(target);
    pending_results.push_back(rec);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic check_result();
    search_record_t  rec;
    divider_result_t got;
    got.m_value = m_axis_tdata[10:0];
    got.n_value = m_axis_tdata[18:11];
    got.p_value = m_axis_tdata[21:19];
    got.found   = m_axis_tuser[0];
    got.vco_low = m_axis_tuser[1];
    if (pending_results.size() == 0) begin
      if (mismatch_count < 10) begin
        $display("%0t: result with nothing outstanding, m=%0d n=%0d p=%0d found=%0b vco_low=%0b",
                 $realtime, got.m_value, got.n_value, got.p_value, got.found, got.vco_low);
      end
      mismatch_count++;
    end else begin
      rec = pending_results.pop_front();
      if (got.m_value !== rec.result.m_value || got.n_value !== rec.result.n_value ||
          got.p_value !== rec.result.p_value || got.found !== rec.result.found ||
          got.vco_low !== rec.result.vco_low) begin
        if (mismatch_count < 10) begin
          $display("%0t: target %0d exp m=%0d n=%0d p=%0d found=%0b vco_low=%0b", $realtime,
                   rec.target, rec.result.m_value, rec.result.n_value, rec.result.p_value,
                   rec.result.found, rec.result.vco_low);
          $display("%0t: target %0d got m=%0d n=%0d p=%0d found=%0b vco_low=%0b", $realtime,
                   rec.target, got.m_value, got.n_value, got.p_value, got.found, got.vco_low);
        end
        mismatch_count++;
      end
    end
  endtask

  // receiver side: random stall bursts, checks each result transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (out_stall_left != 0) begin
        out_stall_left <= out_stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_left <= $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[pll_divider_search_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [pds_pkg::REF_W-1:0]  ref_val;
    logic [pds_pkg::MAXM_W-1:0] max_m_val;
    logic [pds_pkg::MAXN_W-1:0] max_n_val;
    logic [pds_pkg::VCO_W-1:0]  vco_val;

    // reset configuration, extremes of the target and values between them
    add_item(19'd0, 1'b1, 11'd0, 8'd0, 3'd7, 1'b0, 1'b1);
    add_item(19'd524287, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_item(19'd25175, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_item(19'd108000, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // no n searched at all
    add_write(pds_pkg::REG_MAX_N, 20'd0);
    add_item(19'd50000, 1'b1, 11'd0, 8'd0, 3'd2, 1'b0, 1'b0);
    add_write(pds_pkg::REG_MIN_VCO, 20'd0);
    add_item(19'd0, 1'b1, 11'd0, 8'd0, 3'd0, 1'b0, 1'b0);
    add_item(19'd524287, 1'b1, 11'd0, 8'd0, 3'd0, 1'b0, 1'b0);
    add_write(pds_pkg::REG_MIN_VCO, 20'hFFFFF);
    add_item(19'd524287, 1'b1, 11'd0, 8'd0, 3'd2, 1'b0, 1'b0);
    // vco floor out of reach, p saturates
    add_write(pds_pkg::REG_MAX_P, 20'd0);
    add_item(19'd524287, 1'b1, 11'd0, 8'd0, 3'd0, 1'b0, 1'b1);
    // zero reference behaves as 1 khz
    add_write(pds_pkg::REG_MIN_VCO, 20'd0);
    add_write(pds_pkg::REG_REF_CLOCK, 20'd0);
    add_write(pds_pkg::REG_MAX_N, 20'd1);
    add_item(19'd1, 1'b1, 11'd1, 8'd1, 3'd0, 1'b1, 1'b0);
    add_item(19'd2000, 1'b1, 11'd0, 8'd0, 3'd0, 1'b0, 1'b0);
    // every n hits zero error, first one wins
    add_write(pds_pkg::REG_MAX_N, 20'd3);
    add_item(19'd1, 1'b1, 11'd1, 8'd1, 3'd0, 1'b1, 1'b0);
    add_write(pds_pkg::REG_MAX_M, 20'd0);
    add_item(19'd1, 1'b1, 11'd0, 8'd0, 3'd0, 1'b0, 1'b0);
    // rounded quotient is zero for every n
    add_write(pds_pkg::REG_REF_CLOCK, 20'd65535);
    add_write(pds_pkg::REG_MAX_M, 20'd2047);
    add_item(19'd1, 1'b1, 11'd0, 8'd0, 3'd0, 1'b0, 1'b0);
    add_write(pds_pkg::REG_MAX_N, 20'd255);
    add_write(pds_pkg::REG_MAX_P, 20'd7);
    add_write(pds_pkg::REG_MIN_VCO, 20'd400000);
    add_item(19'd524287, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_item(19'd40000, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // writes past the last register must not land anywhere
    add_write(SPARE_REG_LO, 20'hFFFFF);
    add_write(SPARE_REG_HI, 20'd0);
    add_item(19'd40000, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_item(19'd148500, 1'b0, '0, '0, '0, 1'b0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_target(dir_rows[i].target, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on = (ph != NUM_PHASES - 1);
      case ($urandom_range(0, 5))
        0:       ref_val = '0;
        1:       ref_val = 16'd1;
        2:       ref_val = 16'hFFFF;
        default: ref_val = 16'($urandom_range(1000, 50000));
      endcase
      case ($urandom_range(0, 4))
        0:       max_m_val = '0;
        1:       max_m_val = 11'd2047;
        default: max_m_val = 11'($urandom_range(1, 2047));
      endcase
      // only one phase pays for the full n sweep
      if (ph == 2) begin
        max_n_val = 8'd255;
      end else if ($urandom_range(0, 5) == 0) begin
        max_n_val = '0;
      end else begin
        max_n_val = 8'($urandom_range(1, 12));
      end
      case ($urandom_range(0, 4))
        0:       vco_val = '0;
        1:       vco_val = 20'hFFFFF;
        default: vco_val = 20'($urandom_range(0, 300000));
      endcase
      // junk above each register's width must be dropped
      write_reg(pds_pkg::REG_REF_CLOCK, {4'($urandom), ref_val});
      write_reg(pds_pkg::REG_MAX_M, {9'($urandom), max_m_val});
      write_reg(pds_pkg::REG_MAX_N, {12'($urandom), max_n_val});
      write_reg(pds_pkg::REG_MAX_P, {17'($urandom), 3'($urandom)});
      write_reg(pds_pkg::REG_MIN_VCO, vco_val);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_target(random_target(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[pll_divider_search_top] OK");
    end else begin
      $display("[pll_divider_search_top] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/pds_pkg.sv
hw/rtl/pds_div_serial.sv
hw/rtl/pds_mul_serial.sv
hw/rtl/pll_divider_search_top.sv
bench/pll_divider_search_top_tb.sv
